// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock, masked while rst is high
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock, including during reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, limits and stage payload types for the quaternion rotate core.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QuatW     = 16;
  localparam int VecW      = 24;
  localparam int QW        = QuatW + 1;   // quaternion operand, room for -(-2.0)
  localparam int VW        = 28;          // vector / intermediate operand
  localparam int PW        = QW + VW;     // one partial product
  localparam int SW        = PW + 2;      // sum of four products
  localparam int FracShift = 14;
  localparam int RW        = SW - FracShift;
  localparam int MidW      = 28;
  localparam int OutW      = 24;

  localparam logic signed [RW-1:0] MidHi = RW'((64'sd1 <<< (MidW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] MidLo = RW'(-(64'sd1 <<< (MidW - 1)));
  localparam logic signed [RW-1:0] OutHi = RW'((64'sd1 <<< (OutW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] OutLo = RW'(-(64'sd1 <<< (OutW - 1)));

  typedef struct packed {
    logic [3:0][3:0][PW-1:0] m;     // m[i][j] = a_i * b_j
    logic [3:0][QW-1:0]      quat;
    logic                    clip;
  } mul_out_t;

  typedef struct packed {
    logic [3:0][MidW-1:0] r;
    logic [3:0][QW-1:0]   quat;
    logic                 clip;
  } red_out_t;

endpackage

// ----- rtl/core/qvr_mul.sv -----
// ----------------------------------------------------------------------------
// qvr_mul
// Registered stage of the sixteen cross products a_i * b_j.
// ----------------------------------------------------------------------------
module qvr_mul import qvr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0][QW-1:0]   a,
  input  logic [3:0][VW-1:0]   b,
  input  logic [3:0][QW-1:0]   quat_in,
  input  logic                 clip_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mul_out_t             out
);

  mul_out_t out_next;
  logic     valid;

  always_comb begin
    logic signed [PW-1:0] ae;
    logic signed [PW-1:0] be;
    out_next = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        ae = PW'($signed(a[i]));
        be = PW'($signed(b[j]));
        out_next.m[i][j] = ae * be;
      end
    end
    out_next.quat = quat_in;
    out_next.clip = clip_in;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out <= out_next;
    end
  end

endmodule

// ----- rtl/core/qvr_red.sv -----
// ----------------------------------------------------------------------------
// qvr_red
// Hamilton sum of registered products, round to nearest, shift, saturate.
// ----------------------------------------------------------------------------
module qvr_red import qvr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     narrow,      // 1: clamp to output width, 0: intermediate width
  input  logic     in_valid,
  output logic     in_ready,
  input  mul_out_t in,
  output logic     out_valid,
  input  logic     out_ready,
  output red_out_t out
);

  function automatic logic signed [SW-1:0] ext(input logic [PW-1:0] x);
    ext = SW'($signed(x));
  endfunction

  red_out_t out_next;
  logic     valid;

  always_comb begin
    logic signed [SW-1:0] s [4];
    logic signed [SW-1:0] t;
    logic signed [RW-1:0] rnd;
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    logic signed [RW-1:0] c;
    logic                 clip;
    s[0] = ext(in.m[3][0]) + ext(in.m[0][3]) + ext(in.m[1][2]) - ext(in.m[2][1]);
    s[1] = ext(in.m[3][1]) - ext(in.m[0][2]) + ext(in.m[1][3]) + ext(in.m[2][0]);
    s[2] = ext(in.m[3][2]) + ext(in.m[0][1]) - ext(in.m[1][0]) + ext(in.m[2][3]);
    s[3] = ext(in.m[3][3]) - ext(in.m[0][0]) - ext(in.m[1][1]) - ext(in.m[2][2]);
    hi   = narrow ? OutHi : MidHi;
    lo   = narrow ? OutLo : MidLo;
    clip = in.clip;
    out_next = '0;
    for (int k = 0; k < 4; k++) begin
      t   = s[k] + (SW'(1) <<< (FracShift - 1));
      rnd = RW'(t >>> FracShift);
      if (rnd > hi) begin
        c    = hi;
        clip = 1'b1;
      end else if (rnd < lo) begin
        c    = lo;
        clip = 1'b1;
      end else begin
        c = rnd;
      end
      out_next.r[k] = c[MidW-1:0];
    end
    out_next.quat = in.quat;
    out_next.clip = clip;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out <= out_next;
    end
  end

endmodule

// ----- rtl/core/quaternion_vector_rotate.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Fixed-point rotation conj(q) * v * q, four-stage pipeline.
// ----------------------------------------------------------------------------
// Requests enter on s_axis: quaternion (Q1.14) and four-component vector
// (Q12.12). Results leave on m_axis: rotated vector (Q12.12, saturated) and a
// saturation flag on tuser. No configuration, no state between requests.
// Stages: v*q products, sum/round/clamp to 28 bits, conj(q)*p products,
// sum/round/clamp to 24 bits into the output register.
// Pipeline: four register stages, the output register last, so
// m_axis_tvalid, m_axis_tdata and m_axis_tuser are registered.
// Throughput: one request per cycle while m_axis_tready is high; each stage
// holds one multiplier bank or one adder tree.
// Stall: when m_axis_tready is low, stages fill up in turn; s_axis_tready
// drops only once all four stages hold a request. Nothing is dropped or
// repeated.
// Reset: rst clears all stage valid bits; in-flight requests are discarded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, vec_w
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z, out_w
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic [0:0]   m_axis_tuser
);

  logic [3:0][QW-1:0] quat;
  logic [3:0][VW-1:0] vec;
  logic [3:0][QW-1:0] conj;

  mul_out_t mo1;
  mul_out_t mo1_t;
  mul_out_t mo2;
  red_out_t ro1;
  red_out_t ro2;

  logic v1, v2, v3, v4;
  logic r2, r3, r4;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quat[i] = QW'($signed(s_axis_tdata[QuatW*i +: QuatW]));
      vec[i]  = VW'($signed(s_axis_tdata[QuatW*4 + VecW*i +: VecW]));
    end
  end

  qvr_mul u_mul1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .a         (quat),
    .b         (vec),
    .quat_in   (quat),
    .clip_in   (1'b0),
    .out_valid (v1),
    .out_ready (r2),
    .out       (mo1)
  );

  // v * q: term v_i * q_j sits at m[j][i]
  always_comb begin
    mo1_t = mo1;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        mo1_t.m[i][j] = mo1.m[j][i];
      end
    end
  end

  qvr_red u_red1 (
    .clk       (clk),
    .rst       (rst),
    .narrow    (1'b0),
    .in_valid  (v1),
    .in_ready  (r2),
    .in        (mo1_t),
    .out_valid (v2),
    .out_ready (r3),
    .out       (ro1)
  );

  always_comb begin
    conj[0] = -ro1.quat[0];
    conj[1] = -ro1.quat[1];
    conj[2] = -ro1.quat[2];
    conj[3] = ro1.quat[3];
  end

  qvr_mul u_mul2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r3),
    .a         (conj),
    .b         (ro1.r),
    .quat_in   (ro1.quat),
    .clip_in   (ro1.clip),
    .out_valid (v3),
    .out_ready (r4),
    .out       (mo2)
  );

  qvr_red u_red2 (
    .clk       (clk),
    .rst       (rst),
    .narrow    (1'b1),
    .in_valid  (v3),
    .in_ready  (r4),
    .in        (mo2),
    .out_valid (v4),
    .out_ready (m_axis_tready),
    .out       (ro2)
  );

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {ro2.r[3][OutW-1:0], ro2.r[2][OutW-1:0],
                          ro2.r[1][OutW-1:0], ro2.r[0][OutW-1:0]};
  assign m_axis_tuser  = ro2.clip;

  // requests in flight, for checking only
  logic [2:0] inflight;
  logic [2:0] inflight_next;

  always_comb begin
    inflight_next = inflight;
    if (s_axis_tvalid && s_axis_tready) begin
      inflight_next = inflight_next + 3'd1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      inflight_next = inflight_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `ASSERT_CLK(a_occupancy, inflight == 3'($countones({v1, v2, v3, v4})), "stage valids disagree with request count")
  `ASSERT_CLK(a_ready_when_free, !(v1 && v2 && v3 && v4) |-> s_axis_tready, "input stalled with a free stage")
  `ASSERT_ALWAYS(a_empty_after_rst, rst |=> !m_axis_tvalid, "output valid right after reset")

endmodule
